/* hw/rtl/drbt_pkg.sv */
// Shared constants and the button-to-relay table of the relay toggler.
package drbt_pkg;

  localparam int unsigned NumButtonsDef  = 96;
  localparam int unsigned NumRelaysDef   = 32;
  localparam int unsigned RelaysPerBoard = 8;
  localparam int unsigned TableSize      = 96;
  localparam int unsigned QueueDepth     = 2;

  localparam logic [7:0]  PortReg       = 8'h12;
  localparam logic [5:0]  BaseAddr      = 6'h20;
  localparam logic [15:0] DebounceReset = 16'd25;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;

  function automatic int unsigned relay_table(input int unsigned idx);
    int unsigned r;
    r = 1;
    if (idx < 32) begin
      r = idx + 1;
    end else if (idx < 48) begin
      r = 2 * (idx - 32) + 1;
    end else if (idx < 64) begin
      r = 2 * (idx - 48) + 2;
    end else if (idx < 80) begin
      r = 31 - 2 * (idx - 64);
    end else if (idx < 96) begin
      r = 32 - 2 * (idx - 80);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/drbt_front.sv */
// Front end: accept samples, track latches and release timer, queue toggles.
module drbt_front import drbt_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = NumButtonsDef,
  parameter int unsigned NUM_RELAYS  = NumRelaysDef,
  localparam int unsigned RLW = $clog2(NUM_RELAYS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [6:0]     button_index_i,
  input  logic           pressed_i,
  input  logic [5:0]     remote_relay_i,
  input  logic [31:0]    now_ms_i,
  output logic           push_o,
  output logic [RLW-1:0] push_idx_o,
  input  logic           full_i
);

  localparam int unsigned LBW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [15:0]            debounce_q;
  logic [31:0]            last_press_q, last_press_d;
  logic [NUM_BUTTONS-1:0] latched_q, latched_d;
  logic [RLW-1:0]         tab_idx [TableSize];

  for (genvar g = 0; g < TableSize; g++) begin : g_tab
    localparam int unsigned Raw = relay_table(g);
    localparam int unsigned Wrapped = (Raw - 1) % NUM_RELAYS;
    assign tab_idx[g] = RLW'(Wrapped);
  end

  logic           accept, in_range, remote_ok, latched_bit;
  logic [LBW-1:0] btn;
  logic [6:0]     tab_sel;
  logic [31:0]    elapsed;
  logic [RLW-1:0] relay_idx;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign in_range   = 9'(button_index_i) < 9'(NUM_BUTTONS);
  assign btn        = LBW'(button_index_i);
  assign latched_bit = latched_q[btn];
  assign remote_ok  = (remote_relay_i != 6'd0) && (7'(remote_relay_i) <= 7'(NUM_RELAYS));
  assign tab_sel    = (button_index_i >= 7'(TableSize)) ? button_index_i - 7'(TableSize)
                                                        : button_index_i;
  assign relay_idx  = remote_ok ? RLW'(remote_relay_i - 6'd1) : tab_idx[tab_sel];
  assign elapsed    = now_ms_i - last_press_q;

  always_comb begin
    latched_d    = latched_q;
    last_press_d = last_press_q;
    push_o       = 1'b0;
    if (accept && in_range) begin
      if (pressed_i) begin
        last_press_d = now_ms_i;
        if (!latched_bit) begin
          latched_d[btn] = 1'b1;
          push_o         = 1'b1;
        end
      end else if (elapsed > 32'(debounce_q)) begin
        latched_d[btn] = 1'b0;
      end
    end
  end

  assign push_idx_o = relay_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      last_press_q <= '0;
      latched_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        debounce_q <= cfg_wdata_i;
      end
      last_press_q <= last_press_d;
      latched_q    <= latched_d;
    end
  end

endmodule

/* hw/rtl/drbt_fifo.sv */
// Short queue of pending relay toggles between front and back end.
module drbt_fifo import drbt_pkg::*; #(
  parameter int unsigned WIDTH = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = $clog2(QueueDepth);

  logic [WIDTH-1:0] mem [QueueDepth];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [PW:0]      count_q;

  assign full_o  = count_q == (PW+1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign rdata_o = mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PW'(1);
      end
      count_q <= count_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

/* hw/rtl/drbt_back.sv */
// Back end: toggle relay bits in the port image and register the expander write.
module drbt_back import drbt_pkg::*; #(
  parameter int unsigned NUM_RELAYS = NumRelaysDef,
  localparam int unsigned RLW = $clog2(NUM_RELAYS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  logic [RLW-1:0] cmd_idx_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [5:0]     expander_address_o,
  output logic [7:0]     port_register_o,
  output logic [7:0]     port_data_o,
  output logic [5:0]     relay_number_o
);

  localparam int unsigned NB = (NUM_RELAYS + RelaysPerBoard - 1) / RelaysPerBoard;
  localparam int unsigned BW = (NB > 1) ? $clog2(NB) : 1;

  logic [NB-1:0][7:0] image_q, image_d;
  logic               valid_q;
  logic [5:0]         addr_q, relay_q;
  logic [7:0]         data_q;
  logic [BW-1:0]      board;
  logic [2:0]         bit_sel;
  logic [7:0]         new_byte;

  assign cmd_pop_o = cmd_valid_i & (~valid_q | out_ready_i);
  assign board     = BW'(cmd_idx_i >> 3);
  assign bit_sel   = cmd_idx_i[2:0];

  always_comb begin
    new_byte          = image_q[board];
    new_byte[bit_sel] = ~new_byte[bit_sel];
    image_d           = image_q;
    if (cmd_pop_o) begin
      image_d[board] = new_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      addr_q  <= BaseAddr + 6'(board);
      data_q  <= new_byte;
      relay_q <= 6'((RLW+1)'(cmd_idx_i) + (RLW+1)'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_q <= '0;
      valid_q <= 1'b0;
    end else begin
      image_q <= image_d;
      if (cmd_pop_o) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = valid_q;
  assign expander_address_o = addr_q;
  assign port_register_o    = PortReg;
  assign port_data_o        = data_q;
  assign relay_number_o     = relay_q;

endmodule

/* hw/rtl/debounced_button_relay_toggler_core.sv */
// Top level of the debounced button relay toggler.
// A toggling sample is written into the toggle queue, then popped into the output register once that is free.
// Throughput: one sample per cycle; the two-entry toggle queue and output register
// keep that rate while the output is taken every cycle.
// Reset: asynchronous, active low; relays off, latches cleared, timer zero,
// debounce setting 25 ms. No clearing pass is needed.
module debounced_button_relay_toggler_core import drbt_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = NumButtonsDef,
  parameter int unsigned NUM_RELAYS  = NumRelaysDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // button_index[6:0], pressed[7], remote_relay[13:8], now_ms[45:14], zero[47:46]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // expander_address[5:0], port_register[13:6], port_data[21:14],
  // relay_number[27:22], zero[31:28]
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned RLW = $clog2(NUM_RELAYS);

  logic           push, full, pop, q_valid;
  logic [RLW-1:0] push_idx, q_idx;
  logic [5:0]     exp_addr, relay_num;
  logic [7:0]     port_reg, port_dat;

  drbt_front #(
    .NUM_BUTTONS(NUM_BUTTONS),
    .NUM_RELAYS (NUM_RELAYS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .button_index_i(s_axis_tdata[6:0]),
    .pressed_i     (s_axis_tdata[7]),
    .remote_relay_i(s_axis_tdata[13:8]),
    .now_ms_i      (s_axis_tdata[45:14]),
    .push_o        (push),
    .push_idx_o    (push_idx),
    .full_i        (full)
  );

  drbt_fifo #(
    .WIDTH(RLW)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .wdata_i(push_idx),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rdata_o(q_idx)
  );

  drbt_back #(
    .NUM_RELAYS(NUM_RELAYS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i       (q_valid),
    .cmd_idx_i         (q_idx),
    .cmd_pop_o         (pop),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .expander_address_o(exp_addr),
    .port_register_o   (port_reg),
    .port_data_o       (port_dat),
    .relay_number_o    (relay_num)
  );

  assign m_axis_tdata = {4'b0000, relay_num, port_dat, port_reg, exp_addr};

endmodule

/* hw/rtl/drbt_checker.sv */
// Port-level assertions for the relay toggler, bound to the top level.
module drbt_checker import drbt_pkg::*; #(
  parameter int unsigned NUM_RELAYS = NumRelaysDef
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned NB = (NUM_RELAYS + RelaysPerBoard - 1) / RelaysPerBoard;

  logic [5:0] addr, relay, board_of_relay;

  assign addr           = m_axis_tdata[5:0];
  assign relay          = m_axis_tdata[27:22];
  assign board_of_relay = (relay - 6'd1) >> 3;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_port_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[13:6] == PortReg && m_axis_tdata[31:28] == 4'b0000)
    else $error("bad register code or padding");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> addr >= BaseAddr && 7'(addr) < 7'(BaseAddr) + 7'(NB))
    else $error("expander address out of range");

  a_addr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && relay != 6'd0 |-> addr - BaseAddr == board_of_relay)
    else $error("address does not match relay board");

endmodule

bind debounced_button_relay_toggler_core drbt_checker #(
  .NUM_RELAYS(NUM_RELAYS)
) u_drbt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
